@@ sv/shf_pkg.sv @@
// Shared types, constants and the microcode table of the segment header framer.
package shf_pkg;

  localparam int MAX_SEGMENTS      = 16;
  localparam int MAX_SEGMENT_BYTES = 1024;
  localparam int SIZE_LIMIT        = (MAX_SEGMENT_BYTES < 1024) ? MAX_SEGMENT_BYTES : 1024;

  localparam logic [10:0] SIZE_MIN    = 11'd15;
  localparam logic [10:0] SIZE_MAX    = 11'(SIZE_LIMIT);
  localparam logic [4:0]  SEG_LIMIT   = 5'(MAX_SEGMENTS);
  localparam logic [10:0] HDR_BYTES   = 11'd14;
  localparam logic [10:0] SIZE_RESET  = 11'd1024;

  localparam logic [1:0] FUNC_PAYLOAD = 2'd0;
  localparam logic [1:0] FUNC_START   = 2'd1;
  localparam logic [1:0] FUNC_FINISH  = 2'd2;

  localparam logic [1:0] DSEL_CONST = 2'd0;
  localparam logic [1:0] DSEL_SEG   = 2'd1;
  localparam logic [1:0] DSEL_BYTE  = 2'd2;
  localparam logic [1:0] DSEL_COUNT = 2'd3;

  localparam logic [1:0] COND_NONE      = 2'd0;
  localparam logic [1:0] COND_END_START = 2'd1;
  localparam logic [1:0] COND_NEXT_SEG  = 2'd2;

  localparam logic [4:0] PC_HDR      = 5'd0;
  localparam logic [4:0] PC_HDR_LAST = 5'd13;
  localparam logic [4:0] PC_HDR_BYTE = 5'd14;
  localparam logic [4:0] PC_PAYLOAD  = 5'd15;
  localparam logic [4:0] PC_OVERFLOW = 5'd16;
  localparam logic [4:0] PC_FINISH   = 5'd17;
  localparam logic [4:0] PC_FIN_LAST = 5'd20;

  typedef struct packed {
    logic       off_lat;
    logic [3:0] off_c;
    logic [1:0] dsel;
    logic [7:0] dconst;
    logic       err;
    logic       fin;
    logic [1:0] cond;
    logic [4:0] jt;
  } shf_ctrl_t;

  function automatic shf_ctrl_t ucode(input logic [4:0] pc);
    shf_ctrl_t w;
    w = '0;
    w.off_c = pc[3:0];
    w.dsel = DSEL_CONST;
    unique case (pc)
      5'd0: w.dconst = 8'h6F;
      5'd1: w.dconst = 8'h70;
      5'd2: w.dconst = 8'h73;
      5'd3: w.dconst = 8'h70;
      5'd4: w.dconst = 8'h05;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd11, 5'd12: w.dconst = 8'h00;
      5'd10: w.dsel = DSEL_SEG;
      PC_HDR_LAST: w.cond = COND_END_START;
      PC_HDR_BYTE: begin
        w.dsel = DSEL_BYTE;
        w.fin = 1'b1;
      end
      PC_PAYLOAD: begin
        w.off_lat = 1'b1;
        w.dsel = DSEL_BYTE;
        w.fin = 1'b1;
      end
      PC_OVERFLOW: begin
        w.off_c = 4'd0;
        w.err = 1'b1;
        w.fin = 1'b1;
      end
      PC_FINISH: begin
        w.off_c = 4'd6;
        w.dsel = DSEL_COUNT;
      end
      5'd18: w.off_c = 4'd7;
      5'd19: w.off_c = 4'd8;
      PC_FIN_LAST: begin
        w.off_c = 4'd9;
        w.cond = COND_NEXT_SEG;
        w.jt = PC_FINISH;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/shf_if.sv @@
// Valid/ready channel interfaces for the input, result and configuration sides.
interface shf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] payload_byte;
  modport source (output valid, output func, output payload_byte, input ready);
  modport sink (input valid, input func, input payload_byte, output ready);
endinterface

interface shf_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] write_segment;
  logic [9:0] write_offset;
  logic [7:0] write_data;
  logic       overflow_error;
  logic       last_of_run;
  modport source (output valid, output write_segment, output write_offset, output write_data,
                  output overflow_error, output last_of_run, input ready);
  modport sink (input valid, input write_segment, input write_offset, input write_data,
                input overflow_error, input last_of_run, output ready);
endinterface

interface shf_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] segment_size;
  modport source (output valid, output segment_size, input ready);
  modport sink (input valid, input segment_size, output ready);
endinterface

@@ sv/shf_seq.sv @@
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module shf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              launch,
  input  logic [4:0]        launch_pc,
  input  logic              launch_start,
  input  logic              step,
  input  logic              seg_more,
  output logic              busy,
  output shf_pkg::shf_ctrl_t ctrl,
  output logic              last
);

  logic       busy_r, busy_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       start_mode_r, start_mode_nxt;
  logic       jump;

  assign ctrl = shf_pkg::ucode(pc_r);
  assign jump = (ctrl.cond == shf_pkg::COND_NEXT_SEG) && seg_more;
  assign last = ctrl.fin
             || ((ctrl.cond == shf_pkg::COND_END_START) && start_mode_r)
             || ((ctrl.cond == shf_pkg::COND_NEXT_SEG) && !seg_more);
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt = pc_r;
    start_mode_nxt = start_mode_r;
    if (launch) begin
      busy_nxt = 1'b1;
      pc_nxt = launch_pc;
      start_mode_nxt = launch_start;
    end else if (step) begin
      priority if (last) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = ctrl.jt;
      end else begin
        pc_nxt = pc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r <= '0;
      start_mode_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pc_r <= pc_nxt;
      start_mode_r <= start_mode_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= shf_pkg::PC_FIN_LAST)
    else $error("Sequencer step counter left the program.");

  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> !busy_r)
    else $error("Program launched while another one runs.");

endmodule

@@ sv/segment_header_framer.sv @@
// Top level of the segment header framer: state, datapath and output register.
// A payload byte that fits, with the output slot free, shows its write in the next cycle.
// A byte that opens a segment yields 15 writes, start 14, finish 4 * (segments in use);
// these bursts keep the input stalled until the microcode sequencer issues the last write.
// A single write whose output slot is still held goes through the sequencer instead.
// Synchronous active-low reset: segment 0, offset 0, segment size 1024, no results pending.
module segment_header_framer (
  input logic         clk,
  input logic         rst_n,
  shf_in_if.sink      in_ch,
  shf_out_if.source   out_ch,
  shf_cfg_if.sink     cfg_ch
);

  logic [10:0] seg_size_r;
  logic [3:0]  cur_r, cur_nxt;
  logic [10:0] fill_r, fill_nxt;
  logic [3:0]  seg_r, seg_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [9:0]  pay_off_r, pay_off_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_seg_r, out_seg_nxt;
  logic [9:0]  out_off_r, out_off_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_err_r, out_err_nxt;
  logic        out_last_r, out_last_nxt;

  logic [10:0] eff_size;
  logic        out_free;
  logic        acc;
  logic        fits;
  logic        room;
  logic [4:0]  cur_inc;

  logic        launch;
  logic [4:0]  launch_pc;
  logic        launch_start;
  logic        seq_busy;
  logic        seq_step;
  logic        seq_last;
  logic        seg_more;
  shf_pkg::shf_ctrl_t ctrl;

  logic [7:0]  step_data;
  logic [9:0]  step_off;

  always_comb begin
    priority if (seg_size_r < shf_pkg::SIZE_MIN) begin
      eff_size = shf_pkg::SIZE_MIN;
    end else if (seg_size_r > shf_pkg::SIZE_MAX) begin
      eff_size = shf_pkg::SIZE_MAX;
    end else begin
      eff_size = seg_size_r;
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = !seq_busy;
  assign acc = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign seq_step = seq_busy && out_free;
  assign fits = fill_r < eff_size;
  assign cur_inc = {1'b0, cur_r} + 5'd1;
  assign room = cur_inc < shf_pkg::SEG_LIMIT;
  assign seg_more = seg_r != cur_r;

  shf_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .launch       (launch),
    .launch_pc    (launch_pc),
    .launch_start (launch_start),
    .step         (seq_step),
    .seg_more     (seg_more),
    .busy         (seq_busy),
    .ctrl         (ctrl),
    .last         (seq_last)
  );

  always_comb begin
    unique case (ctrl.dsel)
      shf_pkg::DSEL_CONST: step_data = ctrl.dconst;
      shf_pkg::DSEL_SEG:   step_data = {4'd0, seg_r};
      shf_pkg::DSEL_BYTE:  step_data = byte_r;
      shf_pkg::DSEL_COUNT: step_data = {3'd0, cur_inc};
      default:             step_data = 8'd0;
    endcase
    step_off = ctrl.off_lat ? pay_off_r : {6'd0, ctrl.off_c};
  end

  always_comb begin
    cur_nxt = cur_r;
    fill_nxt = fill_r;
    seg_nxt = seg_r;
    byte_nxt = byte_r;
    pay_off_nxt = pay_off_r;
    launch = 1'b0;
    launch_pc = shf_pkg::PC_HDR;
    launch_start = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_seg_nxt = out_seg_r;
    out_off_nxt = out_off_r;
    out_data_nxt = out_data_r;
    out_err_nxt = out_err_r;
    out_last_nxt = out_last_r;

    if (seq_step) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt = seg_r;
      out_off_nxt = step_off;
      out_data_nxt = step_data;
      out_err_nxt = ctrl.err;
      out_last_nxt = seq_last;
      if ((ctrl.cond == shf_pkg::COND_NEXT_SEG) && seg_more) begin
        seg_nxt = seg_r + 4'd1;
      end
    end

    if (acc) begin
      byte_nxt = in_ch.payload_byte;
      unique case (in_ch.func)
        shf_pkg::FUNC_PAYLOAD: begin
          priority if (fits) begin
            fill_nxt = fill_r + 11'd1;
            pay_off_nxt = fill_r[9:0];
            seg_nxt = cur_r;
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_seg_nxt = cur_r;
              out_off_nxt = fill_r[9:0];
              out_data_nxt = in_ch.payload_byte;
              out_err_nxt = 1'b0;
              out_last_nxt = 1'b1;
            end else begin
              launch = 1'b1;
              launch_pc = shf_pkg::PC_PAYLOAD;
            end
          end else if (room) begin
            cur_nxt = cur_inc[3:0];
            seg_nxt = cur_inc[3:0];
            fill_nxt = shf_pkg::HDR_BYTES + 11'd1;
            launch = 1'b1;
            launch_pc = shf_pkg::PC_HDR;
          end else begin
            seg_nxt = cur_r;
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_seg_nxt = cur_r;
              out_off_nxt = 10'd0;
              out_data_nxt = 8'd0;
              out_err_nxt = 1'b1;
              out_last_nxt = 1'b1;
            end else begin
              launch = 1'b1;
              launch_pc = shf_pkg::PC_OVERFLOW;
            end
          end
        end
        shf_pkg::FUNC_START: begin
          cur_nxt = 4'd0;
          seg_nxt = 4'd0;
          fill_nxt = shf_pkg::HDR_BYTES;
          launch = 1'b1;
          launch_pc = shf_pkg::PC_HDR;
          launch_start = 1'b1;
        end
        shf_pkg::FUNC_FINISH: begin
          seg_nxt = 4'd0;
          launch = 1'b1;
          launch_pc = shf_pkg::PC_FINISH;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_size_r <= shf_pkg::SIZE_RESET;
      cur_r <= 4'd0;
      fill_r <= 11'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        seg_size_r <= cfg_ch.segment_size;
      end
      cur_r <= cur_nxt;
      fill_r <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    byte_r <= byte_nxt;
    pay_off_r <= pay_off_nxt;
    out_seg_r <= out_seg_nxt;
    out_off_r <= out_off_nxt;
    out_data_r <= out_data_nxt;
    out_err_r <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.write_segment = out_seg_r;
  assign out_ch.write_offset = out_off_r;
  assign out_ch.write_data = out_data_r;
  assign out_ch.overflow_error = out_err_r;
  assign out_ch.last_of_run = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 11'd1024)
    else $error("Fill offset ran past the largest segment.");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_off_r == 10'd0 && out_data_r == 8'd0 && out_last_r)
    else $error("Dropped byte reported with a nonzero write.");

  a_burst_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.func == shf_pkg::FUNC_START || in_ch.func == shf_pkg::FUNC_FINISH)
    |=> seq_busy && !in_ch.ready)
    else $error("Start or finish did not hold off the next transfer.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r
      && $stable({out_seg_r, out_off_r, out_data_r, out_err_r, out_last_r}))
    else $error("Pending write changed before its transfer.");

endmodule
